### sv/framed_command_receiver_macros.svh
// ----------------------------------------------------------------------------
// Framed command receiver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framed command receiver: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framed command receiver: next-cycle check failed");

`endif

### sv/fcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command receiver package
// Frame constants, parser phase encoding, command codes and result type.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam logic [7:0] SyncByte  = 8'hAA;
  localparam logic [7:0] AckByte   = 8'h06;
  localparam logic [7:0] NakByte   = 8'h15;
  localparam logic [7:0] VelLen    = 8'd17;
  localparam logic [7:0] PingLen   = 8'd9;
  localparam logic [7:0] PingId    = 8'h08;
  localparam logic [7:0] IdVel     = 8'h00;
  localparam logic [7:0] IdOpen    = 8'h01;
  localparam logic [7:0] IdClose   = 8'h02;
  localparam logic [7:0] TimeoutRst = 8'd30;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_VEL   = 3'd1,
    CMD_OPEN  = 3'd2,
    CMD_CLOSE = 3'd3,
    CMD_HSHK  = 3'd4
  } cmd_e;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_REQ_HS  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  reply_byte;
    cmd_e        command;
    logic [31:0] linear_word;
    logic [31:0] angular_word;
    logic        checksum_ok;
    logic        link_ready;
  } result_t;

endpackage

### sv/fcr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command receiver channels
// Input item channel and result channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fcr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface fcr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic [2:0]  command;
  logic [31:0] linear_word;
  logic [31:0] angular_word;
  logic        checksum_ok;
  logic        link_ready;

  modport source (output valid, output reply_byte, output command, output linear_word,
                  output angular_word, output checksum_ok, output link_ready,
                  input ready);
  modport sink (input valid, input reply_byte, input command, input linear_word,
                input angular_word, input checksum_ok, input link_ready,
                output ready);
endinterface

### sv/framed_command_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command receiver
// Parses sync/length/payload/checksum frames from a byte and tick stream and
// returns one reply per completed frame.
//
//   channel   direction  contents
//   frame_i   in         mode (0 byte, 1 tick), rx_byte
//   reply_o   out        reply_byte, command, linear/angular words, flags
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// While no reply is stalled, one item is taken every cycle; a reply appears
// in the cycle after the checksum byte. The result register holds it while
// the sink stalls, and a new item is taken in the cycle the reply leaves.
// Reset clears the parser, the handshake flag and the output valid.
// ----------------------------------------------------------------------------
`include "framed_command_receiver_macros.svh"

module framed_command_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  fcr_in_if.sink     frame_i,
  fcr_out_if.source  reply_o
);

  fcr_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       seen_q, seen_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       cmd_id_q, cmd_id_d;
  logic [63:0]      vel_q, vel_d;
  logic [7:0]       ticks_q, ticks_d;
  logic             hs_done_q, hs_done_d;
  logic [7:0]       tmo_q;
  logic             req_hs_q;
  logic             out_valid_q, out_valid_d;
  fcr_pkg::result_t res_q, res_d;

  logic             take;
  logic             emit;
  logic             ok;
  logic [2:0]       vel_idx;

  assign frame_i.ready = !out_valid_q || reply_o.ready;
  assign take          = frame_i.valid && frame_i.ready;
  assign ok            = (frame_i.rx_byte == xor_q);
  assign vel_idx       = 3'(seen_q - 8'd1);

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    seen_d    = seen_q;
    xor_d     = xor_q;
    cmd_id_d  = cmd_id_q;
    vel_d     = vel_q;
    ticks_d   = ticks_q;
    hs_done_d = hs_done_q;
    emit      = 1'b0;
    res_d     = res_q;
    if (take) begin
      if (frame_i.mode) begin
        if (phase_q == fcr_pkg::PH_BODY || phase_q == fcr_pkg::PH_CHECK) begin
          ticks_d = (ticks_q == 8'hFF) ? ticks_q : ticks_q + 8'd1;
          if (ticks_d > tmo_q) begin
            phase_d = fcr_pkg::PH_HUNT;
          end
        end
      end else begin
        unique case (phase_q)
          fcr_pkg::PH_HUNT: begin
            if (frame_i.rx_byte == fcr_pkg::SyncByte) begin
              phase_d = fcr_pkg::PH_LEN;
            end
          end
          fcr_pkg::PH_LEN: begin
            len_d    = frame_i.rx_byte;
            seen_d   = 8'd0;
            xor_d    = fcr_pkg::SyncByte ^ frame_i.rx_byte;
            cmd_id_d = 8'd0;
            vel_d    = 64'd0;
            ticks_d  = 8'd0;
            phase_d  = (frame_i.rx_byte == 8'd0) ? fcr_pkg::PH_CHECK : fcr_pkg::PH_BODY;
          end
          fcr_pkg::PH_BODY: begin
            if (seen_q == 8'd0) begin
              cmd_id_d = frame_i.rx_byte;
            end else if (seen_q <= 8'd8) begin
              vel_d[{vel_idx, 3'b000} +: 8] = frame_i.rx_byte;
            end
            xor_d  = xor_q ^ frame_i.rx_byte;
            seen_d = seen_q + 8'd1;
            if (seen_d == len_q) begin
              phase_d = fcr_pkg::PH_CHECK;
            end
          end
          fcr_pkg::PH_CHECK: begin
            emit                 = 1'b1;
            phase_d              = fcr_pkg::PH_HUNT;
            res_d.reply_byte     = fcr_pkg::NakByte;
            res_d.command        = fcr_pkg::CMD_NONE;
            res_d.linear_word    = 32'd0;
            res_d.angular_word   = 32'd0;
            res_d.checksum_ok    = ok;
            if (req_hs_q && !hs_done_q) begin
              if (ok && len_q == fcr_pkg::PingLen && cmd_id_q == fcr_pkg::PingId) begin
                hs_done_d        = 1'b1;
                res_d.reply_byte = fcr_pkg::AckByte;
                res_d.command    = fcr_pkg::CMD_HSHK;
              end
            end else if (ok) begin
              res_d.reply_byte = fcr_pkg::AckByte;
              if (len_q != 8'd0) begin
                if (cmd_id_q == fcr_pkg::IdVel) begin
                  if (len_q == fcr_pkg::VelLen) begin
                    res_d.command      = fcr_pkg::CMD_VEL;
                    res_d.linear_word  = vel_q[31:0];
                    res_d.angular_word = vel_q[63:32];
                  end
                end else if (cmd_id_q == fcr_pkg::IdOpen) begin
                  res_d.command = fcr_pkg::CMD_OPEN;
                end else if (cmd_id_q == fcr_pkg::IdClose) begin
                  res_d.command = fcr_pkg::CMD_CLOSE;
                end
              end
            end
            res_d.link_ready = !req_hs_q || hs_done_d;
          end
          default: begin
            phase_d = fcr_pkg::PH_HUNT;
          end
        endcase
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (reply_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fcr_pkg::PH_HUNT;
      len_q       <= 8'd0;
      seen_q      <= 8'd0;
      xor_q       <= 8'd0;
      cmd_id_q    <= 8'd0;
      vel_q       <= 64'd0;
      ticks_q     <= 8'd0;
      hs_done_q   <= 1'b0;
      tmo_q       <= fcr_pkg::TimeoutRst;
      req_hs_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      seen_q      <= seen_d;
      xor_q       <= xor_d;
      cmd_id_q    <= cmd_id_d;
      vel_q       <= vel_d;
      ticks_q     <= ticks_d;
      hs_done_q   <= hs_done_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (fcr_pkg::reg_idx_e'(cfg_idx_i))
          fcr_pkg::REG_TIMEOUT: tmo_q    <= cfg_data_i;
          fcr_pkg::REG_REQ_HS:  req_hs_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign reply_o.valid        = out_valid_q;
  assign reply_o.reply_byte   = res_q.reply_byte;
  assign reply_o.command      = res_q.command;
  assign reply_o.linear_word  = res_q.linear_word;
  assign reply_o.angular_word = res_q.angular_word;
  assign reply_o.checksum_ok  = res_q.checksum_ok;
  assign reply_o.link_ready   = res_q.link_ready;

  `FCR_ASSERT_NEXT(a_reply_after_check, take && !frame_i.mode && phase_q == fcr_pkg::PH_CHECK, out_valid_q)
  `FCR_ASSERT_SAME(a_vel_needs_ack, out_valid_q && res_q.command == fcr_pkg::CMD_VEL, res_q.reply_byte == fcr_pkg::AckByte && res_q.checksum_ok)
  `FCR_ASSERT_SAME(a_hshk_sets_link, out_valid_q && res_q.command == fcr_pkg::CMD_HSHK, res_q.link_ready && hs_done_q)

endmodule

### tb/sv/framed_command_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command receiver testbench
// Drives sync/length/payload/checksum frames mixed with millisecond ticks
// into the receiver and checks every reply against a predictor that tracks
// the parser, the tick timer and the handshake flag. Covers handshake and
// run modes, all commands, timeouts and long stalls on the reply channel.
// ----------------------------------------------------------------------------
module framed_command_receiver_test;
  import fcr_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 1550;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  fcr_in_if  frame_ch ();
  fcr_out_if reply_ch ();

  framed_command_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_ch),
    .reply_o    (reply_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic [7:0]  timeout_cfg = TimeoutRst;
  logic        req_hs_cfg = 1'b1;
  phase_e      rx_phase = PH_HUNT;
  logic [7:0]  frame_len = '0;
  logic [7:0]  body_count = '0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  cmd_id = '0;
  logic [63:0] vel_bytes = '0;
  logic [7:0]  tick_count = '0;
  logic        hs_done = 1'b0;

  result_t pending_replies[$];

  int  work_items = 0;
  int  frames_dropped = 0;
  int  replies_checked = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("framed_command_receiver_test NOT OK");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic octet_q_t random_body(input logic [7:0] id, input int len);
    octet_q_t q;
    for (int i = 0; i < len; i++) q.push_back(i == 0 ? id : 8'($urandom));
    return q;
  endfunction

  task automatic predict_item(input logic m, input logic [7:0] data);
    result_t want;
    logic    ok;
    if (m) begin
      if (rx_phase == PH_BODY || rx_phase == PH_CHECK) begin
        work_items++;
        if (tick_count != 8'hFF) tick_count++;
        if (tick_count > timeout_cfg) begin
          rx_phase = PH_HUNT;
          frames_dropped++;
        end
      end
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (data == SyncByte) begin
            rx_phase = PH_LEN;
            work_items++;
          end
        end
        PH_LEN: begin
          work_items++;
          frame_len = data;
          body_count = '0;
          run_xor = SyncByte ^ data;
          cmd_id = '0;
          vel_bytes = '0;
          tick_count = '0;
          rx_phase = (data == 8'd0) ? PH_CHECK : PH_BODY;
        end
        PH_BODY: begin
          work_items++;
          if (body_count == 8'd0) cmd_id = data;
          else if (body_count <= 8'd8) vel_bytes[8 * (body_count - 1) +: 8] = data;
          run_xor ^= data;
          body_count++;
          if (body_count == frame_len) rx_phase = PH_CHECK;
        end
        default: begin
          work_items++;
          ok = (data == run_xor);
          want.reply_byte = NakByte;
          want.command = CMD_NONE;
          want.linear_word = '0;
          want.angular_word = '0;
          rx_phase = PH_HUNT;
          if (req_hs_cfg && !hs_done) begin
            if (ok && frame_len == PingLen && cmd_id == PingId) begin
              hs_done = 1'b1;
              want.reply_byte = AckByte;
              want.command = CMD_HSHK;
            end
          end else if (ok) begin
            want.reply_byte = AckByte;
            if (frame_len != 8'd0) begin
              case (cmd_id)
                IdVel: begin
                  if (frame_len == VelLen) begin
                    want.command = CMD_VEL;
                    want.linear_word = vel_bytes[31:0];
                    want.angular_word = vel_bytes[63:32];
                  end
                end
                IdOpen: want.command = CMD_OPEN;
                IdClose: want.command = CMD_CLOSE;
                default: ;
              endcase
            end
          end
          want.checksum_ok = ok;
          want.link_ready = !req_hs_cfg || hs_done;
          pending_replies.push_back(want);
        end
      endcase
    end
  endtask

  task automatic send_item(input logic m, input logic [7:0] data);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 25) ? pick_idle() : 0;
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.mode <= m;
    frame_ch.rx_byte <= data;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    predict_item(m, data);
  endtask

  // Completes whatever frame the parser is inside so the next one starts clean.
  task automatic resync();
    while (rx_phase != PH_HUNT) send_item(1'b0, 8'h00);
  endtask

  task automatic send_frame(input octet_q_t body, input bit corrupt, input int ticks);
    logic [7:0] sum;
    int         left;
    int         n;
    sum = SyncByte ^ 8'(body.size());
    foreach (body[i]) sum ^= body[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_item(1'b0, SyncByte);
    send_item(1'b0, 8'(body.size()));
    left = ticks;
    for (int i = 0; i <= body.size(); i++) begin
      if (i == body.size()) n = left;
      else n = (left > 0 && $urandom_range(0, body.size()) == 0) ? $urandom_range(1, left) : 0;
      repeat (n) send_item(1'b1, 8'($urandom));
      left -= n;
      if (i < body.size()) send_item(1'b0, body[i]);
    end
    send_item(1'b0, sum);
    resync();
  endtask

  task automatic drain_replies();
    frame_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_TIMEOUT: timeout_cfg = value;
      REG_REQ_HS: req_hs_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at reply %0d: %s got 0x%0h, expected 0x%0h",
             replies_checked, what, got, want);
  endtask

  initial begin
    int      stall_left;
    result_t want;
    stall_left = 0;
    reply_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (reply_ch.valid && reply_ch.ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("reply with none pending, reply byte",
                          32'(reply_ch.reply_byte), 32'd0);
        end else begin
          want = pending_replies.pop_front();
          if (reply_ch.reply_byte !== want.reply_byte)
            report_mismatch("reply byte", 32'(reply_ch.reply_byte), 32'(want.reply_byte));
          if (reply_ch.command !== want.command)
            report_mismatch("command", 32'(reply_ch.command), 32'(want.command));
          if (reply_ch.linear_word !== want.linear_word)
            report_mismatch("linear word", reply_ch.linear_word, want.linear_word);
          if (reply_ch.angular_word !== want.angular_word)
            report_mismatch("angular word", reply_ch.angular_word, want.angular_word);
          if (reply_ch.checksum_ok !== want.checksum_ok)
            report_mismatch("checksum ok", 32'(reply_ch.checksum_ok), 32'(want.checksum_ok));
          if (reply_ch.link_ready !== want.link_ready)
            report_mismatch("link ready", 32'(reply_ch.link_ready), 32'(want.link_ready));
        end
        replies_checked++;
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        reply_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_idle() - 1;
        reply_ch.ready <= 1'b0;
      end else begin
        reply_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_handshake_phase();
    send_item(1'b0, 8'h55);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame(random_body(IdOpen, 1), 1'b0, 0);
    send_frame(random_body(PingId, 9), 1'b1, 0);
    send_frame(random_body(PingId, 8), 1'b0, 0);
    send_frame(random_body(IdVel, 0), 1'b0, 0);
    send_frame(random_body(PingId, 9), 1'b0, 31);
    drain_replies();
    write_reg(REG_REQ_HS, 8'd0);
    send_frame(random_body(IdOpen, 1), 1'b0, 0);
    send_frame(random_body(IdVel, 0), 1'b0, 0);
    drain_replies();
    write_reg(REG_REQ_HS, 8'd1);
    send_frame(random_body(PingId, 9), 1'b0, 30);
    drain_replies();
  endtask

  task automatic test_run_commands();
    octet_q_t body;
    body = random_body(IdVel, 17);
    for (int i = 1; i < 17; i++) body[i] = 8'hFF;
    send_frame(body, 1'b0, 0);
    for (int i = 1; i < 17; i++) body[i] = 8'h00;
    send_frame(body, 1'b0, 0);
    send_frame(random_body(IdVel, 17), 1'b0, 0);
    send_frame(random_body(IdVel, 9), 1'b0, 0);
    send_frame(random_body(IdVel, 18), 1'b0, 0);
    send_frame(random_body(IdClose, 1), 1'b0, 0);
    send_frame(random_body(IdOpen, 5), 1'b0, 0);
    send_frame(random_body(8'hFF, 2), 1'b0, 0);
    send_frame(random_body(PingId, 9), 1'b0, 0);
    send_frame(random_body(IdVel, 0), 1'b0, 0);
    send_frame(random_body(IdVel, 17), 1'b1, 0);
    send_frame(random_body(8'($urandom), 255), 1'b0, 0);
    drain_replies();
  endtask

  task automatic test_frame_timeout();
    write_reg(REG_TIMEOUT, 8'd1);
    send_frame(random_body(IdOpen, 1), 1'b0, 1);
    send_frame(random_body(IdClose, 3), 1'b0, 2);
    send_frame(random_body(IdVel, 0), 1'b0, 2);
    send_item(1'b0, SyncByte);
    repeat (3) send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h01);
    send_item(1'b0, IdClose);
    send_item(1'b0, SyncByte ^ 8'h01 ^ IdClose);
    drain_replies();
    write_reg(REG_TIMEOUT, 8'd255);
    send_frame(random_body(IdVel, 17), 1'b0, 300);
    drain_replies();
  endtask

  task automatic test_reply_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_request = 150;
    repeat (25) send_frame(random_body(IdClose, 1), 1'b0, 0);
    drain_replies();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic random_frame();
    int         r;
    int         len;
    logic [7:0] id;
    int         ticks;
    r = $urandom_range(0, 99);
    len = r < 8 ? 0 : r < 32 ? 17 : r < 42 ? 9 :
          r < 92 ? $urandom_range(1, 24) : $urandom_range(25, 255);
    r = $urandom_range(0, 99);
    id = r < 35 ? IdVel : r < 55 ? IdOpen : r < 75 ? IdClose : r < 85 ? PingId :
         8'($urandom);
    ticks = 0;
    if ($urandom_range(0, 4) == 0)
      ticks = (timeout_cfg <= 8'd40) ? $urandom_range(1, timeout_cfg + 1)
                                     : $urandom_range(1, 8);
    send_frame(random_body(id, len), $urandom_range(0, 9) == 0, ticks);
  endtask

  task automatic random_noise();
    int cnt;
    cnt = $urandom_range(1, 6);
    repeat (cnt) begin
      if ($urandom_range(0, 4) == 0) send_item(1'b0, SyncByte);
      else send_item(1'($urandom), 8'($urandom));
    end
    resync();
  endtask

  task automatic broken_frame();
    int len;
    int cut;
    len = $urandom_range(2, 12);
    cut = $urandom_range(0, len - 1);
    send_item(1'b0, SyncByte);
    send_item(1'b0, 8'(len));
    repeat (cut) send_item(1'b0, 8'($urandom));
    if (timeout_cfg <= 8'd40) repeat (timeout_cfg + 1) send_item(1'b1, 8'($urandom));
    resync();
  endtask

  task automatic test_random_frames();
    int chunk_end;
    int r;
    for (int p = 0; work_items < ItemTarget; p++) begin
      drain_replies();
      case (p % 5)
        0: write_reg(REG_TIMEOUT, 8'd1);
        1: write_reg(REG_TIMEOUT, 8'd255);
        2: write_reg(REG_TIMEOUT, 8'($urandom_range(2, 12)));
        3: write_reg(REG_TIMEOUT, 8'($urandom_range(13, 254)));
        default: write_reg(REG_TIMEOUT, TimeoutRst);
      endcase
      write_reg(REG_REQ_HS, 8'($urandom_range(0, 1)));
      gaps_on = (p % 3 != 0);
      stalls_on = (p % 3 != 0);
      chunk_end = work_items + 300;
      while (work_items < chunk_end && work_items < ItemTarget) begin
        r = $urandom_range(0, 99);
        if (r < 72) random_frame();
        else if (r < 87) random_noise();
        else broken_frame();
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TIMEOUT;
    cfg_data_i = '0;
    frame_ch.valid = 1'b0;
    frame_ch.mode = 1'b0;
    frame_ch.rx_byte = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_handshake_phase();
    test_run_commands();
    test_frame_timeout();
    test_reply_backpressure();
    test_random_frames();
    drain_replies();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d replies over %0d frame bytes and timer ticks, %0d frames timed out.",
             replies_checked, work_items, frames_dropped);
    $display("Run spanned handshake and run modes, every command, timeouts of 1 to 255 ticks.");
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("framed_command_receiver_test OK");
    end else begin
      $display("framed_command_receiver_test NOT OK");
    end
    $finish;
  end

endmodule
